// ===== rtl/core/mio_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mio_pkg
// Shared constants and controller/datapath handshake types for the
// maximum interval overlap block.
// ----------------------------------------------------------------------------
package mio_pkg;

  localparam int unsigned MaxIntervalsDef = 256;
  localparam int unsigned PointW          = 32;
  localparam int unsigned KeyW            = PointW + 1;
  localparam int unsigned OverlapW        = 9;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_INS_RD = 6'b000010,
    S_INS_CMP = 6'b000100,
    S_SW_RD  = 6'b001000,
    S_SW_ACC = 6'b010000,
    S_EMIT   = 6'b100000
  } mio_state_e;

  typedef struct packed {
    logic in_rdy;
    logic ins_rd;
    logic ins_cmp;
    logic sw_init;
    logic sw_rd;
    logic sw_acc;
    logic emit;
  } mio_cmd_t;

  typedef struct packed {
    logic take;
    logic in_fits;
    logic in_last;
    logic pos_zero;
    logic shift;
    logic ev_end;
    logic last;
    logic sw_done;
    logic out_free;
  } mio_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/mio_intf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mio_intf
// Valid/ready channels for interval beats and overlap result beats.
// ----------------------------------------------------------------------------
interface mio_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_point;
  logic signed [31:0] end_point;
  logic               last_interval;

  modport source (output valid, output start_point, output end_point,
                  output last_interval, input ready);
  modport sink (input valid, input start_point, input end_point,
                input last_interval, output ready);
endinterface

interface mio_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] best_point;
  logic        [8:0]  max_overlap;
  logic               overflowed;

  modport source (output valid, output best_point, output max_overlap,
                  output overflowed, input ready);
  modport sink (input valid, input best_point, input max_overlap,
                input overflowed, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mio_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mio_ctrl
// Sequencer: sorted insert of two events per interval, then the sweep.
// ----------------------------------------------------------------------------
module mio_ctrl
  import mio_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire mio_stat_t stat_i,
  output mio_cmd_t       cmd_o
);

  mio_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_rdy = 1'b1;
        if (stat_i.take) begin
          if (stat_i.in_fits) begin
            state_d = S_INS_RD;
          end else if (stat_i.in_last) begin
            cmd_o.sw_init = 1'b1;
            state_d       = S_SW_RD;
          end
        end
      end
      S_INS_RD, S_INS_CMP: begin
        cmd_o.ins_rd  = (state_q == S_INS_RD);
        cmd_o.ins_cmp = (state_q == S_INS_CMP);
        if (state_q == S_INS_RD && !stat_i.pos_zero) begin
          state_d = S_INS_CMP;
        end else if (state_q == S_INS_CMP && stat_i.shift) begin
          state_d = S_INS_RD;
        end else if (!stat_i.ev_end) begin
          // start event placed, insert the end event next
          state_d = S_INS_RD;
        end else if (stat_i.last) begin
          cmd_o.sw_init = 1'b1;
          state_d       = S_SW_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SW_RD: begin
        cmd_o.sw_rd = 1'b1;
        state_d     = stat_i.sw_done ? S_EMIT : S_SW_ACC;
      end
      S_SW_ACC: begin
        cmd_o.sw_acc = 1'b1;
        state_d      = S_SW_RD;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state register not one-hot");
  a_emit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> state_q == S_IDLE)
    else $error("emit did not return to idle");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.take |-> state_q == S_IDLE)
    else $error("beat taken outside idle");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/mio_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mio_dp
// Event store, sorted insert shifter, sweep accumulator and result register.
// ----------------------------------------------------------------------------
module mio_dp
  import mio_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = MaxIntervalsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire mio_cmd_t cmd_i,
  output mio_stat_t     stat_o,
  mio_in_if.sink        in_i,
  mio_out_if.source     out_o
);

  localparam int unsigned Depth = 2 * MAX_INTERVALS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = $clog2(Depth + 1);
  localparam int unsigned SW    = $clog2(MAX_INTERVALS + 1) + 1;

  logic [KeyW-1:0] mem [Depth];
  logic [KeyW-1:0] rdata_q;

  logic [CW-1:0]  count_q, count_d;
  logic           dropped_q, dropped_d;
  logic           out_valid_q, out_valid_d;
  logic [AW-1:0]  pos_q;
  logic [KeyW-1:0] key_q, end_key_q;
  logic           is_end_q, last_q;
  logic [CW-1:0]  idx_q;
  logic signed [SW-1:0] cur_q, max_q, cur_n;
  logic [PointW-1:0] best_q;
  logic signed [PointW-1:0] best_out_q;
  logic [OverlapW-1:0] ovl_out_q;
  logic           ovf_out_q;

  logic           take, shift, pos_zero, place, mem_we, fits;
  logic [AW-1:0]  rd_addr;
  logic [KeyW-1:0] wdata;
  logic [31:0]    max_ext;

  assign take     = in_i.valid && in_i.ready;
  assign in_i.ready = cmd_i.in_rdy;
  assign shift    = rdata_q > key_q;
  assign pos_zero = (pos_q == '0);
  assign place    = (cmd_i.ins_rd && pos_zero) || (cmd_i.ins_cmp && !shift);
  assign mem_we   = place || (cmd_i.ins_cmp && shift);
  assign wdata    = place ? key_q : rdata_q;
  assign rd_addr  = cmd_i.sw_rd ? idx_q[AW-1:0] : pos_q - AW'(1);
  assign fits     = ({1'b0, count_q} + (CW+1)'(2)) <= (CW+1)'(Depth);
  assign cur_n    = rdata_q[0] ? cur_q - SW'(1) : cur_q + SW'(1);
  assign max_ext  = 32'($unsigned(max_q));

  assign stat_o.take     = take;
  assign stat_o.in_fits  = fits;
  assign stat_o.in_last  = in_i.last_interval;
  assign stat_o.pos_zero = pos_zero;
  assign stat_o.shift    = shift;
  assign stat_o.ev_end   = is_end_q;
  assign stat_o.last     = last_q;
  assign stat_o.sw_done  = (idx_q == count_q);
  assign stat_o.out_free = !out_valid_q || out_o.ready;

  assign out_o.valid       = out_valid_q;
  assign out_o.best_point  = best_out_q;
  assign out_o.max_overlap = ovl_out_q;
  assign out_o.overflowed  = ovf_out_q;

  // store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[pos_q] <= wdata;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    count_d     = count_q;
    dropped_d   = dropped_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (take && !fits) dropped_d = 1'b1;
    if (place) count_d = count_q + CW'(1);
    if (cmd_i.emit) begin
      count_d     = '0;
      dropped_d   = 1'b0;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      key_q     <= {~in_i.start_point[31], in_i.start_point[30:0], 1'b0};
      end_key_q <= {~in_i.end_point[31], in_i.end_point[30:0], 1'b1};
      is_end_q  <= 1'b0;
      pos_q     <= count_q[AW-1:0];
      last_q    <= in_i.last_interval;
    end else if (place && !is_end_q) begin
      key_q    <= end_key_q;
      is_end_q <= 1'b1;
      pos_q    <= count_q[AW-1:0] + AW'(1);
    end else if (cmd_i.ins_cmp && shift) begin
      pos_q <= pos_q - AW'(1);
    end
    if (cmd_i.sw_init) begin
      idx_q  <= '0;
      cur_q  <= '0;
      max_q  <= '0;
      best_q <= '0;
    end else if (cmd_i.sw_acc) begin
      idx_q <= idx_q + CW'(1);
      cur_q <= cur_n;
      if (cur_n > max_q) begin
        max_q  <= cur_n;
        best_q <= {~rdata_q[32], rdata_q[31:1]};
      end
    end
    if (cmd_i.emit) begin
      best_out_q <= best_q;
      ovl_out_q  <= max_ext[OverlapW-1:0];
      ovf_out_q  <= dropped_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("event count beyond store depth");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_o.ready))
    else $error("result overwritten before taken");
  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> count_q == '0 && !dropped_q)
    else $error("set not cleared after result");
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> {1'b0, pos_q} <= (AW+1)'(count_q))
    else $error("store write beyond filled region");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/max_interval_overlap.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// max_interval_overlap
// Largest number of overlapping intervals by a sweep over sorted events.
// ----------------------------------------------------------------------------
// Each interval beat adds a start and an end event to a store of
// 2*MAX_INTERVALS entries kept sorted by point (start before end at equal
// points, so touching intervals overlap). Every event is placed by an
// insertion pass over the single-port-read store: each entry above the new
// key is read, compared and shifted up one place before the key is written.
// The beat marked last then starts a sweep with one store read and one
// accumulate per event, after which the result register is loaded once the
// output is free. Intervals that do not fit are dropped and reported in the
// overflowed bit; the last beat still closes the set. A result waits in its
// register while the next set starts.
// ----------------------------------------------------------------------------
module max_interval_overlap
  import mio_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = MaxIntervalsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mio_in_if.sink    in_i,
  mio_out_if.source out_o
);

  mio_cmd_t  cmd;
  mio_stat_t stat;

  // sequencer: decides each step of insert and sweep
  mio_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // store, shifter, accumulator and result register
  mio_dp #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

// ===== tb/max_interval_overlap_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_interval_overlap_test
// Self-checking bench for the maximum interval overlap block.
// ----------------------------------------------------------------------------
// Interval beats go in through a valid/ready channel and overlap result beats
// come out through another. A behavioral sorted-event model computes each
// expected result when a last beat is accepted. A table of directed sets runs
// first, then random sets of mostly small sizes, with a few sets that fill
// the store and overflow it. Both sides insert random idle gaps between beats.
// ----------------------------------------------------------------------------
module max_interval_overlap_test;
  import mio_pkg::*;

  localparam int Cap = MaxIntervalsDef;
  localparam int WatchLimit = 40 * Cap * 2 + 2000;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               fin;
  } span_t;

  typedef struct packed {
    logic signed [31:0] point;
    logic        [8:0]  depth;
    logic               ovf;
  } peak_t;

  typedef struct {
    span_t span;
    bit    known;  // expected result typed in below
    peak_t peak;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mio_in_if  in_if ();
  mio_out_if out_if ();

  max_interval_overlap u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state: sorted event keys {biased point, end flag}.
  logic [32:0] keys[$];
  bit          lost;
  peak_t       peak_q[$];
  int          errors = 0;
  int          beats_in = 0;
  int          peaks_seen = 0;
  int          ovf_seen = 0;
  int          idle_cnt = 0;

  function automatic logic [32:0] key_of(logic signed [31:0] p, bit is_end);
    return {p ^ 32'h8000_0000, is_end};
  endfunction

  function automatic void place_key(logic [32:0] k);
    int pos;
    pos = keys.size();
    while (pos > 0 && keys[pos-1] > k) pos--;
    keys.insert(pos, k);
  endfunction

  // Take in one interval beat; on a last beat sweep and queue the peak.
  function automatic void take_span(span_t s);
    int    run;
    int    best;
    peak_t pk;
    if (keys.size() + 2 <= 2 * Cap) begin
      place_key(key_of(s.lo, 1'b0));
      place_key(key_of(s.hi, 1'b1));
    end else begin
      lost = 1'b1;
    end
    if (!s.fin) return;
    run = 0;
    best = 0;
    pk = '0;
    foreach (keys[i]) begin
      run += keys[i][0] ? -1 : 1;
      if (run > best) begin
        best = run;
        pk.point = keys[i][32:1] ^ 32'h8000_0000;
      end
    end
    pk.depth = best[8:0];
    pk.ovf = lost;
    peak_q.push_back(pk);
    keys.delete();
    lost = 1'b0;
  endfunction

  // Result side: random stall, check each accepted beat against the oldest.
  initial begin
    int    stall;
    peak_t pk, got;
    out_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got = {out_if.best_point, out_if.max_overlap, out_if.overflowed};
        peaks_seen++;
        if (got.ovf) ovf_seen++;
        if (peak_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          pk = peak_q.pop_front();
          if (got.point !== pk.point)
            $display("%0t: best_point expected %0d actual %0d", $time, pk.point, got.point);
          if (got.depth !== pk.depth)
            $display("%0t: max_overlap expected %0d actual %0d", $time, pk.depth, got.depth);
          if (got.ovf !== pk.ovf)
            $display("%0t: overflowed expected %0b actual %0b", $time, pk.ovf, got.ovf);
          if (got !== pk) errors++;
        end
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_if.ready <= 1'b1;
    end
  end

  // Watchdog: count cycles with no beat accepted on either side.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Drive one interval beat: idle gap, then hold valid until accepted.
  task automatic send_span(span_t s);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.start_point   <= s.lo;
    in_if.end_point     <= s.hi;
    in_if.last_interval <= s.fin;
    do @(posedge clk_i); while (!in_if.ready);
    take_span(s);
    beats_in++;
  endtask

  function automatic logic signed [31:0] rand_point(int spread);
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom_range(0, spread)) - spread / 2;
    endcase
  endfunction

  task automatic send_set(int n, int spread);
    span_t s;
    for (int i = 0; i < n; i++) begin
      s.lo = rand_point(spread);
      // mostly well-formed spans, some reversed
      if ($urandom_range(0, 7) == 0) s.hi = rand_point(spread);
      else s.hi = s.lo + $signed($urandom_range(0, spread));
      if ($signed(s.hi) < $signed(s.lo) && $urandom_range(0, 3) != 0) s.hi = s.lo;
      s.fin = (i == n - 1);
      send_span(s);
    end
  endtask

  row_t rows[$];

  function automatic row_t mk(int lo, int hi, bit fin, bit known = 0,
                              int pt = 0, int dp = 0, bit ovf = 0);
    row_t r;
    r.span = '{lo: lo, hi: hi, fin: fin};
    r.known = known;
    r.peak = '{point: pt, depth: 9'(dp), ovf: ovf};
    return r;
  endfunction

  initial begin
    int settle;
    in_if.valid = 1'b0;
    in_if.start_point = '0;
    in_if.end_point = '0;
    in_if.last_interval = 1'b0;
    lost = 1'b0;

    // single spans at the extremes, touching, nested, reversed
    rows.push_back(mk(0, 0, 1, 1, 0, 1));
    rows.push_back(mk(32'sh8000_0000, 32'sh7fff_ffff, 1, 1, 32'sh8000_0000, 1));
    rows.push_back(mk(32'sh7fff_ffff, 32'sh7fff_ffff, 1, 1, 32'sh7fff_ffff, 1));
    rows.push_back(mk(32'sh8000_0000, 32'sh8000_0000, 1, 1, 32'sh8000_0000, 1));
    rows.push_back(mk(5, -5, 1, 1, 0, 0));                  // reversed alone
    rows.push_back(mk(1, 5, 0));
    rows.push_back(mk(5, 9, 1, 1, 5, 2));                   // touching spans
    rows.push_back(mk(-10, 10, 0));
    rows.push_back(mk(-3, 3, 0));
    rows.push_back(mk(-1, 1, 0));
    rows.push_back(mk(20, 30, 1));
    rows.push_back(mk(9, 2, 0));
    rows.push_back(mk(0, 12, 0));
    rows.push_back(mk(32'sh7fff_fff0, 32'sh8000_0010, 1));
    rows.push_back(mk(-1, -1, 0));
    rows.push_back(mk(-1, -1, 1, 1, -1, 2));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_span(rows[i].span);
      if (rows[i].known && peak_q.size() > 0 && peak_q[$] !== rows[i].peak) begin
        $display("%0t: table row %0d expected %h actual %h", $time, i,
                 rows[i].peak, peak_q[$]);
        errors++;
      end
    end

    // hold off until every result is back
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (peak_q.size() != 0);

    // fill the store exactly, then overflow it with three dropped, last one too
    send_set(Cap, 1000);
    send_set(Cap + 3, 1 << 20);

    while (beats_in < 750) begin
      if ($urandom_range(0, 15) == 0) begin
        in_if.valid <= 1'b0;
        do @(posedge clk_i); while (peak_q.size() != 0);
      end
      send_set($urandom_range(1, 12), ($urandom_range(0, 1) ? 40 : 1 << 24));
    end
    in_if.valid <= 1'b0;

    while (peak_q.size() != 0) @(posedge clk_i);
    settle = 0;
    while (settle < 200) begin
      @(posedge clk_i);
      settle++;
    end

    $display("Sent %0d interval beats; checked %0d results, %0d with overflow.",
             beats_in, peaks_seen, ovf_seen);
    if (errors == 0 && peak_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
